// File: sv/lpfp_pkg.sv
`default_nettype none

package lpfp_pkg;

   localparam int POINTS_PER_FRAME_DEF = 40;

   localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
   localparam logic [7:0]  SYNC_NIBBLES   = 8'hA5;
   localparam logic [6:0]  START_SCALE    = 7'd100;
   localparam logic [21:0] FULL_TURN      = 22'd2304000;
   localparam logic [15:0] ANGLE_STEP_RST = 16'd4512;
   localparam logic [21:0] REV_JUMP_RST   = 22'd2240000;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN,
      PH_DATA
   } phase_type;

   typedef enum logic [0:0] {
      CSR_ANGLE_STEP,
      CSR_REVOLUTION_JUMP
   } csr_index_type;

   typedef enum logic [2:0] {
      EM_IDLE,
      EM_BASE,
      EM_ANGLE,
      EM_DIFF,
      EM_PUSH
   } emit_state_type;

   typedef struct packed {
      logic        start;
      logic [14:0] start_raw;
   } frame_done_type;

endpackage

`default_nettype wire

// File: sv/lidar_point_frame_parser.sv
// Lidar frame parser: one received byte per beat in, one point per beat out.
// Input channel req_*: one byte of the serial stream per beat. The parser
// hunts for three 0xFF bytes, takes the next byte as payload length and
// consumes that payload. A payload of 4 + 2*POINTS_PER_FRAME bytes with good
// sync nibbles and checksum yields POINTS_PER_FRAME points on rsp_*.
// Other frames are dropped without output.
// Bytes are taken one per cycle while req_stall is low. After the last
// byte of a good frame, req_stall stays high while the points are
// generated: the emitter loads the base angle, then for each point runs
// its sequence (angle wrap, angle difference, output push) behind the
// registered read of the distance memory.
// A stall on rsp_stall holds the output register and the emitter at its push step;
// input resumes after the last point is loaded, even if it still waits.
// csr_*: angle_step (index 0) and revolution_jump (index 1); write only
// while the block is idle.
// Reset (synchronous) returns to header hunting, restores the register
// defaults and clears the previous-angle history; no clearing pass.
`default_nettype none

module lidar_point_frame_parser #(
   parameter int POINTS_PER_FRAME = lpfp_pkg::POINTS_PER_FRAME_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [15:0] rsp_range_mm,
   output      logic [21:0] rsp_angle,
   output      logic        rsp_new_revolution,
   output      logic [5:0]  rsp_point_index,
   output      logic        rsp_last_point,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [21:0] csr_write_data
);

   localparam int IDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;

   logic [15:0] angle_step_ff, angle_step_in;
   logic [21:0] rev_jump_ff, rev_jump_in;

   logic                     byte_take;
   logic                     busy;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic [15:0]              mem_wdata;
   logic [IDX_W-1:0]         mem_raddr;
   logic [15:0]              mem_rdata;
   lpfp_pkg::frame_done_type frame_done;

   assign req_stall = busy;
   assign byte_take = req_valid && !req_stall;

   always_comb begin
      angle_step_in = angle_step_ff;
      rev_jump_in   = rev_jump_ff;
      if (csr_write_enable) begin
         case (lpfp_pkg::csr_index_type'(csr_index))
            lpfp_pkg::CSR_ANGLE_STEP:      angle_step_in = csr_write_data[15:0];
            lpfp_pkg::CSR_REVOLUTION_JUMP: rev_jump_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_step_ff <= lpfp_pkg::ANGLE_STEP_RST;
         rev_jump_ff   <= lpfp_pkg::REV_JUMP_RST;
      end else begin
         angle_step_ff <= angle_step_in;
         rev_jump_ff   <= rev_jump_in;
      end
   end

   lpfp_byte_parser #(
      .POINTS_PER_FRAME (POINTS_PER_FRAME),
      .IDX_W            (IDX_W)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_take  (byte_take),
      .data_byte  (req_data_byte),
      .mem_we     (mem_we),
      .mem_addr   (mem_waddr),
      .mem_wdata  (mem_wdata),
      .frame_done (frame_done)
   );

   lpfp_dist_mem #(
      .DEPTH  (POINTS_PER_FRAME),
      .ADDR_W (IDX_W)
   ) u_dist_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   lpfp_point_emit #(
      .POINTS_PER_FRAME (POINTS_PER_FRAME),
      .IDX_W            (IDX_W)
   ) u_emit (
      .clock              (clock),
      .reset              (reset),
      .frame_done         (frame_done),
      .angle_step         (angle_step_ff),
      .revolution_jump    (rev_jump_ff),
      .rd_addr            (mem_raddr),
      .rd_data            (mem_rdata),
      .busy               (busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_range_mm       (rsp_range_mm),
      .rsp_angle          (rsp_angle),
      .rsp_new_revolution (rsp_new_revolution),
      .rsp_point_index    (rsp_point_index),
      .rsp_last_point     (rsp_last_point)
   );

   // no point follows the last one of a frame without a new frame in between
   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_point) |=> !rsp_valid)
      else $error("point issued right after the last point of a frame");

   // input stays held while a point other than the last one waits at the output
   a_hold_input_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_point) |-> req_stall)
      else $error("input taken while a frame is still being emitted");

   // a burst starts only right after an accepted byte
   a_burst_after_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("emitter started without an accepted byte");

endmodule

`default_nettype wire

// File: sv/lpfp_dist_mem.sv
`default_nettype none

module lpfp_dist_mem #(
   parameter int DEPTH  = lpfp_pkg::POINTS_PER_FRAME_DEF,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [15:0]       wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [15:0]       rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/lpfp_byte_parser.sv
`default_nettype none

module lpfp_byte_parser #(
   parameter int POINTS_PER_FRAME = lpfp_pkg::POINTS_PER_FRAME_DEF,
   parameter int IDX_W            = 6
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   byte_take,
   input  wire logic [7:0]             data_byte,
   output      logic                   mem_we,
   output      logic [IDX_W-1:0]       mem_addr,
   output      logic [15:0]            mem_wdata,
   output      lpfp_pkg::frame_done_type frame_done
);

   localparam logic [7:0] FRAME_LEN = 8'(4 + 2 * POINTS_PER_FRAME);

   lpfp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  ff_run_ff, ff_run_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  check_ff, check_in;
   logic [7:0]  sync_ff, sync_in;
   logic [14:0] start_raw_ff, start_raw_in;
   logic [7:0]  lo_ff, lo_in;

   logic [7:0] count_inc;
   logic [7:0] offset;
   logic [6:0] point_sel;
   logic       last_byte;

   assign count_inc = byte_count_ff + 8'd1;
   assign last_byte = (count_inc == frame_length_ff);
   assign offset    = byte_count_ff - 8'd4;
   assign point_sel = offset[7:1];

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (byte_take) begin
         case (phase_ff)
            lpfp_pkg::PH_HUNT: begin
               if (data_byte == lpfp_pkg::SYNC_BYTE && ff_run_ff == 2'd2) begin
                  phase_in = lpfp_pkg::PH_LEN;
               end
            end
            lpfp_pkg::PH_LEN: begin
               phase_in = (data_byte == 8'd0) ? lpfp_pkg::PH_HUNT : lpfp_pkg::PH_DATA;
            end
            lpfp_pkg::PH_DATA: begin
               if (last_byte) begin
                  phase_in = lpfp_pkg::PH_HUNT;
               end
            end
            default: phase_in = lpfp_pkg::PH_HUNT;
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      ff_run_in        = ff_run_ff;
      frame_length_in  = frame_length_ff;
      byte_count_in    = byte_count_ff;
      xor_in           = xor_ff;
      check_in         = check_ff;
      sync_in          = sync_ff;
      start_raw_in     = start_raw_ff;
      lo_in            = lo_ff;
      mem_we           = 1'b0;
      mem_addr         = IDX_W'(point_sel);
      mem_wdata        = {data_byte, lo_ff};
      frame_done.start = 1'b0;
      frame_done.start_raw = start_raw_ff;
      if (byte_take) begin
         case (phase_ff)
            lpfp_pkg::PH_HUNT: begin
               if (data_byte == lpfp_pkg::SYNC_BYTE) begin
                  ff_run_in = (ff_run_ff == 2'd2) ? 2'd0 : ff_run_ff + 2'd1;
               end else begin
                  ff_run_in = 2'd0;
               end
            end
            lpfp_pkg::PH_LEN: begin
               frame_length_in = data_byte;
               byte_count_in   = 8'd0;
               xor_in          = 8'd0;
            end
            lpfp_pkg::PH_DATA: begin
               if (byte_count_ff == 8'd0) begin
                  sync_in  = {data_byte[7:4], sync_ff[3:0]};
                  check_in = {check_ff[7:4], data_byte[3:0]};
               end else if (byte_count_ff == 8'd1) begin
                  sync_in  = {sync_ff[7:4], data_byte[7:4]};
                  check_in = {data_byte[3:0], check_ff[3:0]};
               end else begin
                  xor_in = xor_ff ^ data_byte;
                  if (byte_count_ff == 8'd2) begin
                     start_raw_in = {start_raw_ff[14:8], data_byte};
                  end else if (byte_count_ff == 8'd3) begin
                     start_raw_in = {data_byte[6:0], start_raw_ff[7:0]};
                  end else if (32'(point_sel) < POINTS_PER_FRAME) begin
                     // hold the low byte, write the whole entry with the high byte
                     if (!offset[0]) begin
                        lo_in = data_byte;
                     end else begin
                        mem_we = 1'b1;
                     end
                  end
               end
               byte_count_in = count_inc;
               if (last_byte) begin
                  ff_run_in = 2'd0;
                  frame_done.start = (frame_length_ff == FRAME_LEN) &&
                                     (xor_in == check_in) &&
                                     (sync_in == lpfp_pkg::SYNC_NIBBLES);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= lpfp_pkg::PH_HUNT;
         ff_run_ff       <= 2'd0;
         frame_length_ff <= 8'd0;
         byte_count_ff   <= 8'd0;
         xor_ff          <= 8'd0;
         check_ff        <= 8'd0;
         sync_ff         <= 8'd0;
         start_raw_ff    <= 15'd0;
      end else begin
         phase_ff        <= phase_in;
         ff_run_ff       <= ff_run_in;
         frame_length_ff <= frame_length_in;
         byte_count_ff   <= byte_count_in;
         xor_ff          <= xor_in;
         check_ff        <= check_in;
         sync_ff         <= sync_in;
         start_raw_ff    <= start_raw_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
   end

endmodule

`default_nettype wire

// File: sv/lpfp_point_emit.sv
`default_nettype none

module lpfp_point_emit #(
   parameter int POINTS_PER_FRAME = lpfp_pkg::POINTS_PER_FRAME_DEF,
   parameter int IDX_W            = 6
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lpfp_pkg::frame_done_type frame_done,
   input  wire logic [15:0]              angle_step,
   input  wire logic [21:0]              revolution_jump,
   output      logic [IDX_W-1:0]         rd_addr,
   input  wire logic [15:0]              rd_data,
   output      logic                     busy,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [15:0]              rsp_range_mm,
   output      logic [21:0]              rsp_angle,
   output      logic                     rsp_new_revolution,
   output      logic [5:0]               rsp_point_index,
   output      logic                     rsp_last_point
);

   localparam longint MAX_SUM = 64'd3276700 + 64'd65535 * (POINTS_PER_FRAME - 1);
   localparam int     ACC_W   = $clog2(MAX_SUM + 1);
   localparam logic [IDX_W-1:0] LAST_K = IDX_W'(POINTS_PER_FRAME - 1);

   lpfp_pkg::emit_state_type state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [21:0]      ang_ff, ang_in;
   logic [21:0]      diff_ff, diff_in;
   logic [21:0]      prev_ff, prev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      dist_ff, dist_in;
   logic [21:0]      angle_ff, angle_in;
   logic             newrev_ff, newrev_in;
   logic [5:0]       index_ff, index_in;
   logic             last_ff, last_in;

   logic             slot_free;
   logic             push;
   logic [21:0]      base;
   logic [ACC_W-1:0] wrapped;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign base      = 22'(frame_done.start_raw) * 22'(lpfp_pkg::START_SCALE);
   assign wrapped   = (acc_ff >= ACC_W'(lpfp_pkg::FULL_TURN)) ?
                      acc_ff - ACC_W'(lpfp_pkg::FULL_TURN) : acc_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpfp_pkg::EM_IDLE:  if (frame_done.start) state_in = lpfp_pkg::EM_BASE;
         lpfp_pkg::EM_BASE:  state_in = lpfp_pkg::EM_ANGLE;
         lpfp_pkg::EM_ANGLE: state_in = lpfp_pkg::EM_DIFF;
         lpfp_pkg::EM_DIFF:  state_in = lpfp_pkg::EM_PUSH;
         lpfp_pkg::EM_PUSH: begin
            if (slot_free) begin
               state_in = (k_ff == LAST_K) ? lpfp_pkg::EM_IDLE : lpfp_pkg::EM_ANGLE;
            end
         end
         default: state_in = lpfp_pkg::EM_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      push         = 1'b0;
      k_in         = k_ff;
      acc_in       = acc_ff;
      ang_in       = ang_ff;
      diff_in      = diff_ff;
      prev_in      = prev_ff;
      dist_in      = dist_ff;
      angle_in     = angle_ff;
      newrev_in    = newrev_ff;
      index_in     = index_ff;
      last_in      = last_ff;
      case (state_ff)
         lpfp_pkg::EM_BASE: begin
            k_in   = '0;
            acc_in = ACC_W'(base);
         end
         lpfp_pkg::EM_ANGLE: begin
            ang_in = wrapped[21:0];
         end
         lpfp_pkg::EM_DIFF: begin
            diff_in = (ang_ff > prev_ff) ? ang_ff - prev_ff : prev_ff - ang_ff;
         end
         lpfp_pkg::EM_PUSH: begin
            if (slot_free) begin
               push      = 1'b1;
               dist_in   = rd_data;
               angle_in  = ang_ff;
               newrev_in = diff_ff > revolution_jump;
               index_in  = 6'(k_ff);
               last_in   = (k_ff == LAST_K);
               prev_in   = ang_ff;
               acc_in    = acc_ff + ACC_W'(angle_step);
               k_in      = k_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpfp_pkg::EM_IDLE;
         k_ff         <= '0;
         prev_ff      <= 22'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      ang_ff    <= ang_in;
      diff_ff   <= diff_in;
      dist_ff   <= dist_in;
      angle_ff  <= angle_in;
      newrev_ff <= newrev_in;
      index_ff  <= index_in;
      last_ff   <= last_in;
   end

   assign rd_addr            = k_ff;
   assign busy               = (state_ff != lpfp_pkg::EM_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_range_mm       = dist_ff;
   assign rsp_angle          = angle_ff;
   assign rsp_new_revolution = newrev_ff;
   assign rsp_point_index    = index_ff;
   assign rsp_last_point     = last_ff;

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int POINTS         = lpfp_pkg::POINTS_PER_FRAME_DEF;
   localparam int FRAME_BYTES    = 4 + 2 * POINTS;
   localparam int IDLE_SETTLE    = 12;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic [15:0] range_mm;
      logic [21:0] angle;
      logic        new_revolution;
      logic [5:0]  point_index;
      logic        last_point;
   } lidar_point_type;

   typedef enum {FR_GOOD, FR_BAD_SYNC, FR_BAD_CHECK, FR_ODD_LENGTH} frame_kind_type;
   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   class lidar_point_scoreboard;
      lidar_point_type expected_points[$];
      int              errors;

      logic [15:0]         angle_step;
      logic [21:0]         revolution_jump;
      logic [1:0]          ff_run;
      lpfp_pkg::phase_type phase;
      logic [7:0]          frame_length;
      logic [7:0]          byte_count;
      logic [7:0]          xor_acc;
      logic [7:0]          expected_check;
      logic [7:0]          sync_bits;
      logic [14:0]         start_raw;
      logic [15:0]         distances [POINTS];
      logic [21:0]         prev_angle;

      function new();
         errors           = 0;
         angle_step       = lpfp_pkg::ANGLE_STEP_RST;
         revolution_jump  = lpfp_pkg::REV_JUMP_RST;
         ff_run           = '0;
         phase            = lpfp_pkg::PH_HUNT;
         frame_length     = '0;
         byte_count       = '0;
         xor_acc          = '0;
         expected_check   = '0;
         sync_bits        = '0;
         start_raw        = '0;
         prev_angle       = '0;
         foreach (distances[i]) distances[i] = '0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void set_register(lpfp_pkg::csr_index_type idx, logic [21:0] value);
         case (idx)
            lpfp_pkg::CSR_ANGLE_STEP:      angle_step = value[15:0];
            lpfp_pkg::CSR_REVOLUTION_JUMP: revolution_jump = value;
            default: ;
         endcase
      endfunction

      function void take_body_byte(logic [7:0] b);
         int p;
         if (byte_count == 0) begin
            sync_bits[7:4]      = b[7:4];
            expected_check[3:0] = b[3:0];
         end else if (byte_count == 1) begin
            sync_bits[3:0]      = b[7:4];
            expected_check[7:4] = b[3:0];
         end else begin
            xor_acc ^= b;
            if (byte_count == 2) start_raw[7:0] = b;
            else if (byte_count == 3) start_raw[14:8] = b[6:0];
            else begin
               p = (byte_count - 4) >> 1;
               if (p < POINTS) begin
                  if (byte_count[0] == 1'b0) distances[p][7:0] = b;
                  else distances[p][15:8] = b;
               end
            end
         end
      endfunction

      // Angle in 1/6400 degree: start (1/64 degree) times 100 plus k steps, wrapped once.
      function void emit_frame();
         logic [31:0]     total;
         logic [21:0]     ang;
         logic [21:0]     diff;
         lidar_point_type pt;
         for (int k = 0; k < POINTS; k++) begin
            total = 32'(start_raw) * 32'(lpfp_pkg::START_SCALE) + 32'(angle_step) * 32'(k);
            if (total >= 32'(lpfp_pkg::FULL_TURN)) total = total - 32'(lpfp_pkg::FULL_TURN);
            ang  = total[21:0];
            diff = (ang > prev_angle) ? ang - prev_angle : prev_angle - ang;
            pt.range_mm       = distances[k];
            pt.angle          = ang;
            pt.new_revolution = (diff > revolution_jump);
            pt.point_index    = 6'(k);
            pt.last_point     = (k == POINTS - 1);
            expected_points   = {expected_points, pt};
            prev_angle = ang;
         end
      endfunction

      function void note_byte(logic [7:0] b);
         case (phase)
            lpfp_pkg::PH_HUNT: begin
               if (b == lpfp_pkg::SYNC_BYTE) begin
                  if (ff_run == 2'd2) begin
                     ff_run = '0;
                     phase  = lpfp_pkg::PH_LEN;
                  end else ff_run++;
               end else ff_run = '0;
            end
            lpfp_pkg::PH_LEN: begin
               frame_length = b;
               byte_count   = '0;
               xor_acc      = '0;
               phase        = (b == 8'd0) ? lpfp_pkg::PH_HUNT : lpfp_pkg::PH_DATA;
            end
            default: begin
               take_body_byte(b);
               byte_count++;
               if (byte_count >= frame_length) begin
                  phase  = lpfp_pkg::PH_HUNT;
                  ff_run = '0;
                  if (frame_length == FRAME_BYTES && xor_acc == expected_check &&
                      sync_bits == lpfp_pkg::SYNC_NIBBLES)
                     emit_frame();
               end
            end
         endcase
      endfunction

      task check_point(lidar_point_type got);
         lidar_point_type want;
         if (expected_points.size() == 0) begin
            report($sformatf("point %0d arrived with none pending", got.point_index));
            return;
         end
         want = expected_points[0];
         expected_points.delete(0);
         if (got.range_mm !== want.range_mm)
            report($sformatf("point %0d range %0d, want %0d", want.point_index,
                             got.range_mm, want.range_mm));
         if (got.angle !== want.angle)
            report($sformatf("point %0d angle %0d, want %0d", want.point_index,
                             got.angle, want.angle));
         if (got.new_revolution !== want.new_revolution)
            report($sformatf("point %0d new_revolution %b, want %b", want.point_index,
                             got.new_revolution, want.new_revolution));
         if (got.point_index !== want.point_index)
            report($sformatf("point_index %0d, want %0d", got.point_index, want.point_index));
         if (got.last_point !== want.last_point)
            report($sformatf("point %0d last_point %b, want %b", want.point_index,
                             got.last_point, want.last_point));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_range_mm;
   logic [21:0] rsp_angle;
   logic        rsp_new_revolution;
   logic [5:0]  rsp_point_index;
   logic        rsp_last_point;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [21:0] csr_write_data;

   lidar_point_scoreboard board = new();

   logic [7:0] stream[$];
   int         sender_idle_max = 6;
   int         recv_idle_max = 6;
   bit         long_hold_request = 1'b0;

   lidar_point_frame_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_range_mm       (rsp_range_mm),
      .rsp_angle          (rsp_angle),
      .rsp_new_revolution (rsp_new_revolution),
      .rsp_point_index    (rsp_point_index),
      .rsp_last_point     (rsp_last_point),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic void add_byte(logic [7:0] value);
      stream = {stream, value};
   endfunction

   // Build one frame: header, length byte, then the payload cut or padded to length.
   function automatic void add_frame(frame_kind_type kind, logic [15:0] start_word,
                                     fill_type fill, int length = FRAME_BYTES);
      logic [7:0] body[$];
      logic [7:0] chk;
      logic [7:0] sync;
      logic [7:0] b;
      logic [7:0] head0;
      logic [7:0] head1;
      logic [3:0] mask;
      chk  = '0;
      sync = lpfp_pkg::SYNC_NIBBLES;
      mask = 4'($urandom_range(1, 15));
      b    = start_word[7:0];
      body = {body, b};
      b    = start_word[15:8];
      body = {body, b};
      for (int i = 0; i < 2 * POINTS; i++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            default:   b = 8'($urandom);
         endcase
         body = {body, b};
      end
      foreach (body[j]) chk ^= body[j];
      if (kind == FR_BAD_SYNC) begin
         if ($urandom_range(0, 1)) sync[7:4] ^= mask;
         else sync[3:0] ^= mask;
      end else if (kind == FR_BAD_CHECK) begin
         if ($urandom_range(0, 1)) chk[7:4] ^= mask;
         else chk[3:0] ^= mask;
      end
      head0 = {sync[7:4], chk[3:0]};
      head1 = {sync[3:0], chk[7:4]};
      body  = {head0, head1, body};
      repeat (3) add_byte(lpfp_pkg::SYNC_BYTE);
      add_byte(8'(length));
      for (int i = 0; i < length; i++) begin
         b = (i < body.size()) ? body[i] : 8'($urandom);
         add_byte(b);
      end
   endfunction

   // Noise leans toward 0xFF so that partial header runs show up.
   function automatic void add_noise(int count);
      repeat (count)
         add_byte(($urandom_range(0, 2) == 0) ? lpfp_pkg::SYNC_BYTE : 8'($urandom));
   endfunction

   task automatic send_byte(logic [7:0] value);
      int gap;
      gap = $urandom_range(0, sender_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_byte(value);
   endtask

   task automatic send_stream();
      logic [7:0] value;
      while (stream.size() != 0) begin
         value = stream[0];
         stream.delete(0);
         send_byte(value);
      end
   endtask

   // Drop valid and let every pending point drain before touching registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.expected_points.size() != 0);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_register(lpfp_pkg::csr_index_type idx, logic [21:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      board.set_register(idx, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [15:0] step, logic [21:0] jump);
      wait_idle();
      write_register(lpfp_pkg::CSR_ANGLE_STEP, {6'd0, step});
      write_register(lpfp_pkg::CSR_REVOLUTION_JUMP, jump);
   endtask

   // Point receiver: random stall after beats, occasional stall while idle, long hold on request.
   initial begin : receiver
      int              stall_left;
      bit              accepted;
      lidar_point_type got;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         accepted = (reset === 1'b0) && (rsp_valid === 1'b1) && (rsp_stall === 1'b0);
         if (accepted) begin
            got.range_mm       = rsp_range_mm;
            got.angle          = rsp_angle;
            got.new_revolution = rsp_new_revolution;
            got.point_index    = rsp_point_index;
            got.last_point     = rsp_last_point;
            board.check_point(got);
         end
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall_left        = LONG_HOLD;
         end else if (stall_left == 0 && (accepted || $urandom_range(0, 15) == 0))
            stall_left = $urandom_range(0, recv_idle_max);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else rsp_stall <= 1'b0;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data_byte    <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= lpfp_pkg::CSR_ANGLE_STEP;
      csr_write_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short cases: noise, a zero-length frame, a one-byte frame
      add_noise(4);
      add_byte(8'h00);
      add_frame(FR_ODD_LENGTH, 16'($urandom), FILL_RANDOM, 0);
      add_frame(FR_ODD_LENGTH, 16'($urandom), FILL_RANDOM, 1);
      send_stream();

      // hold the point side off while a good frame streams in, with a broken one back to back behind it
      sender_idle_max   = 0;
      long_hold_request = 1'b1;
      add_frame(FR_GOOD, 16'hFFFF, FILL_ONES);
      add_frame($urandom_range(0, 1) ? FR_BAD_SYNC : FR_BAD_CHECK, 16'($urandom),
                FILL_RANDOM);
      send_stream();
      sender_idle_max = 6;

      // largest step from the top start angle leaves the angle past a full turn
      configure(16'hFFFF, 22'($urandom_range(0, 2303999)));
      add_frame(FR_GOOD, 16'hFFFF, FILL_RANDOM);
      send_stream();

      wait_idle();
      repeat (20) @(posedge clock);
      if (board.expected_points.size() != 0)
         board.report($sformatf("%0d points never arrived", board.expected_points.size()));
      if (board.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// File: filelist.f
sv/lpfp_pkg.sv
sv/lpfp_dist_mem.sv
sv/lpfp_byte_parser.sv
sv/lpfp_point_emit.sv
sv/lidar_point_frame_parser.sv
bench/testbench.sv
